[rtl/jse_pkg.sv]
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants for the JSON string escaper: input kinds,
// character codes and the request passed from the front end to the emitter.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_LAST = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef enum logic [2:0] {
        M_NONE,
        M_LIT,
        M_ESC,
        M_HEX,
        M_SEQ
    } main_op_t;

    typedef struct packed {
        logic       open_quote;
        logic [2:0] pre_n;
        main_op_t   main_op;
        logic [7:0] main_byte;
        logic [1:0] seq_n;
        logic [7:0] held0;
        logic [7:0] held1;
        logic [7:0] held2;
        logic [1:0] post_n;
        logic       close_quote;
    } jse_cmd_t;

endpackage

[rtl/jse_front.sv]
// ----------------------------------------------------------------------------
// jse_front
// Accepts input bytes, tracks the open quote and pending UTF-8 sequence, and
// turns each item into at most one emit request for the back end.
// ----------------------------------------------------------------------------
module jse_front
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       push,
    output jse_cmd_t   cmd
);

    logic       open_reg;
    logic       open_next;
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [7:0] held_reg [3];

    logic       accept;
    logic       lead_we;
    logic       cont_we;
    logic       do_fresh;
    logic       has_out;
    logic [2:0] need;

    function automatic logic fits(input logic [7:0] lead, input logic [1:0] pos,
                                  input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 2'd1)
        begin
            if (lead == 8'hE0)
                lo = 8'hA0;
            else if (lead == 8'hED)
                hi = 8'h9F;
            else if (lead == 8'hF0)
                lo = 8'h90;
            else if (lead == 8'hF4)
                hi = 8'h8F;
        end
        return (b >= lo) && (b <= hi);
    endfunction

    assign accept = in_valid && !q_full;

    always_comb
    begin
        if (held_reg[0] < 8'hE0)
            need = 3'd2;
        else if (held_reg[0] < 8'hF0)
            need = 3'd3;
        else
            need = 3'd4;
    end

    always_comb
    begin
        cmd             = '0;
        cmd.main_op     = M_NONE;
        cmd.open_quote  = !open_reg;
        cmd.main_byte   = data_byte;
        cmd.held0       = held_reg[0];
        cmd.held1       = held_reg[1];
        cmd.held2       = held_reg[2];
        held_count_next = held_count_reg;
        lead_we         = 1'b0;
        cont_we         = 1'b0;
        do_fresh        = 1'b0;
        open_next       = 1'b1;

        if (!kind[1])
        begin
            if (held_count_reg == 2'd0)
                do_fresh = 1'b1;
            else if (!fits(held_reg[0], held_count_reg, data_byte))
            begin
                cmd.pre_n       = {1'b0, held_count_reg};
                held_count_next = 2'd0;
                do_fresh        = 1'b1;
            end
            else if (({1'b0, held_count_reg} + 3'd1) >= need)
            begin
                cmd.main_op     = M_SEQ;
                cmd.seq_n       = held_count_reg;
                held_count_next = 2'd0;
            end
            else
            begin
                cont_we         = 1'b1;
                held_count_next = held_count_reg + 2'd1;
            end
        end

        if (do_fresh)
        begin
            if (data_byte[7])
            begin
                if (data_byte >= 8'hC2 && data_byte <= 8'hF4)
                begin
                    lead_we         = 1'b1;
                    held_count_next = 2'd1;
                end
                else
                    cmd.pre_n = cmd.pre_n + 3'd1;
            end
            else
            begin
                cmd.main_op = M_ESC;
                case (data_byte)
                    8'h22:   cmd.main_byte = CH_QUOTE;
                    8'h5C:   cmd.main_byte = CH_BSLASH;
                    8'h08:   cmd.main_byte = CH_LOW_B;
                    8'h0C:   cmd.main_byte = CH_LOW_F;
                    8'h0A:   cmd.main_byte = CH_LOW_N;
                    8'h0D:   cmd.main_byte = CH_LOW_R;
                    8'h09:   cmd.main_byte = CH_LOW_T;
                    default: cmd.main_op = (data_byte < 8'h20) ? M_HEX : M_LIT;
                endcase
            end
        end

        if (kind != KIND_BYTE)
        begin
            cmd.post_n      = held_count_next;
            cmd.close_quote = 1'b1;
            held_count_next = 2'd0;
            open_next       = 1'b0;
        end
    end

    assign has_out = cmd.open_quote || (cmd.pre_n != 3'd0) || (cmd.main_op != M_NONE)
                     || (cmd.post_n != 2'd0) || cmd.close_quote;
    assign push    = accept && has_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            held_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            open_reg       <= open_next;
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && lead_we)
            held_reg[0] <= data_byte;
        if (accept && cont_we && held_count_reg == 2'd1)
            held_reg[1] <= data_byte;
        if (accept && cont_we && held_count_reg == 2'd2)
            held_reg[2] <= data_byte;
    end

endmodule

[rtl/jse_queue.sv]
// ----------------------------------------------------------------------------
// jse_queue
// Small request FIFO between the front end and the character emitter.
// ----------------------------------------------------------------------------
module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jse_cmd_t wr_data,
    input  logic     pop,
    output logic     full,
    output logic     rd_valid,
    output jse_cmd_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jse_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

[rtl/jse_back.sv]
// ----------------------------------------------------------------------------
// jse_back
// Character emitter: walks a request through its quote, replacement, main and
// closing parts into the output register, one character per unstalled cycle.
// ----------------------------------------------------------------------------
module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  jse_cmd_t   q_data,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       string_done
);

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_PRE,
        PH_MAIN,
        PH_POST,
        PH_CLOSE
    } phase_t;

    phase_t     ph_reg, ph_next;
    logic       busy_reg, busy_next;
    logic [2:0] ci_reg, ci_next;
    logic [2:0] rc_reg, rc_next;
    jse_cmd_t   cmd_reg, cmd_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       run_last_reg, run_last_next;
    logic       done_reg, done_next;

    logic [4:0] ne_cur;
    logic [4:0] ne_new;
    logic [4:0] ne_after;
    logic [7:0] cur_char;
    logic       seg_end;
    logic       is_close;
    logic       last;
    logic       adv;
    logic       emit;
    logic       load;
    phase_t     nx_ph;
    phase_t     first_ph;

    function automatic logic [4:0] nonempty(input jse_cmd_t c);
        return {c.close_quote, (c.post_n != 2'd0), (c.main_op != M_NONE),
                (c.pre_n != 3'd0), c.open_quote};
    endfunction

    function automatic phase_t lowest(input logic [4:0] v);
        phase_t p;
        p = PH_CLOSE;
        for (int i = 4; i >= 0; i--)
        begin
            if (v[i])
                p = phase_t'(3'(i));
        end
        return p;
    endfunction

    function automatic logic [2:0] rep_count(input phase_t p, input jse_cmd_t c);
        logic [2:0] n;
        case (p)
            PH_PRE:  n = c.pre_n;
            PH_POST: n = {1'b0, c.post_n};
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
    endfunction

    function automatic logic [7:0] rep_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = CH_BSLASH;
            3'd1:    c = 8'h75;
            3'd2:    c = CH_LOW_F;
            3'd3:    c = CH_LOW_F;
            3'd4:    c = CH_LOW_F;
            default: c = 8'h64;
        endcase
        return c;
    endfunction

    assign ne_cur   = nonempty(cmd_reg);
    assign ne_new   = nonempty(q_data);
    assign first_ph = lowest(ne_new);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
            ne_after[i] = ne_cur[i] && (3'(i) > ph_reg);
    end

    assign nx_ph = lowest(ne_after);

    always_comb
    begin
        cur_char = CH_QUOTE;
        seg_end  = 1'b1;
        is_close = 1'b0;
        case (ph_reg)
            PH_OPEN:
            begin
                cur_char = CH_QUOTE;
            end
            PH_PRE, PH_POST:
            begin
                cur_char = rep_char(ci_reg);
                seg_end  = (ci_reg == 3'd5) && (rc_reg == 3'd1);
            end
            PH_MAIN:
            begin
                case (cmd_reg.main_op)
                    M_LIT:
                    begin
                        cur_char = cmd_reg.main_byte;
                    end
                    M_ESC:
                    begin
                        cur_char = (ci_reg == 3'd0) ? CH_BSLASH : cmd_reg.main_byte;
                        seg_end  = (ci_reg == 3'd1);
                    end
                    M_HEX:
                    begin
                        case (ci_reg)
                            3'd0:    cur_char = CH_BSLASH;
                            3'd1:    cur_char = 8'h75;
                            3'd2:    cur_char = 8'h30;
                            3'd3:    cur_char = 8'h30;
                            3'd4:    cur_char = hex_char(cmd_reg.main_byte[7:4]);
                            default: cur_char = hex_char(cmd_reg.main_byte[3:0]);
                        endcase
                        seg_end = (ci_reg == 3'd5);
                    end
                    M_SEQ:
                    begin
                        if (ci_reg == {1'b0, cmd_reg.seq_n})
                            cur_char = cmd_reg.main_byte;
                        else if (ci_reg == 3'd0)
                            cur_char = cmd_reg.held0;
                        else if (ci_reg == 3'd1)
                            cur_char = cmd_reg.held1;
                        else
                            cur_char = cmd_reg.held2;
                        seg_end = (ci_reg == {1'b0, cmd_reg.seq_n});
                    end
                    default:
                    begin
                        cur_char = cmd_reg.main_byte;
                    end
                endcase
            end
            PH_CLOSE:
            begin
                is_close = 1'b1;
            end
            default:
            begin
                cur_char = CH_QUOTE;
            end
        endcase
    end

    assign last = seg_end && (ne_after == 5'd0);
    assign adv  = !out_valid_reg || !out_stall;
    assign emit = busy_reg && adv;
    assign load = q_valid && (!busy_reg || (emit && last));
    assign pop  = load;

    always_comb
    begin
        ph_next        = ph_reg;
        busy_next      = busy_reg;
        ci_next        = ci_reg;
        rc_next        = rc_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;
        done_next      = done_reg;

        if (adv)
        begin
            out_valid_next = emit;
            out_char_next  = cur_char;
            run_last_next  = last;
            done_next      = is_close;
        end

        if (load)
        begin
            cmd_next  = q_data;
            busy_next = 1'b1;
            ph_next   = first_ph;
            ci_next   = 3'd0;
            rc_next   = rep_count(first_ph, q_data);
        end
        else if (emit)
        begin
            if (last)
                busy_next = 1'b0;
            else if (seg_end)
            begin
                ph_next = nx_ph;
                ci_next = 3'd0;
                rc_next = rep_count(nx_ph, cmd_reg);
            end
            else if ((ph_reg == PH_PRE || ph_reg == PH_POST) && ci_reg == 3'd5)
            begin
                ci_next = 3'd0;
                rc_next = rc_reg - 3'd1;
            end
            else
                ci_next = ci_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_OPEN;
            busy_reg      <= 1'b0;
            ci_reg        <= 3'd0;
            rc_reg        <= 3'd0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= 8'd0;
            run_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            ph_reg        <= ph_next;
            busy_reg      <= busy_next;
            ci_reg        <= ci_next;
            rc_reg        <= rc_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            run_last_reg  <= run_last_next;
            done_reg      <= done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign run_last    = run_last_reg;
    assign string_done = done_reg;

`ifndef SYNTH
    a_close_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> out_char == CH_QUOTE && run_last)
        else $error("closing quote malformed");

    a_rep_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (ph_reg == PH_PRE || ph_reg == PH_POST) |-> rc_reg != 3'd0 && ci_reg <= 3'd5)
        else $error("replacement counter out of range");

    a_phase_present: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ne_cur[ph_reg])
        else $error("emitter in a phase its request does not have");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !busy_reg || (emit && last))
        else $error("request popped while emitter busy");
`endif

endmodule

[rtl/json_string_escaper.sv]
// ----------------------------------------------------------------------------
// json_string_escaper
// Streams string bytes in and JSON string literal characters out, with
// escaping of control, quote and backslash characters and UTF-8 validation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): kind 0 is a byte inside a string, kind 1
// the final byte of a string, kind 2 or 3 ends the string with no byte.
// Output channel (out_valid/out_stall): one character per transfer; run_last
// marks the last character caused by an input item, string_done marks the
// closing quote.
// The front end classifies each item as it is accepted and queues a request;
// while out_stall is low the emitter sends one character per cycle and plain
// bytes stream at one per cycle. An item gives 1 output character for a plain
// byte and up to 25 for a broken 4-byte sequence plus the closing quote.
// Requests pass through a queue entry and the command and output registers.
// Items that only extend a pending UTF-8 sequence produce no characters.
// in_stall rises when the request queue is full; out_stall holds the output
// register and backs up into the queue.
// Reset clears the open-string flag, pending sequence count, queue and
// output register; the block accepts input as soon as reset is released.
// ----------------------------------------------------------------------------
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       string_done
);

    jse_cmd_t wr_cmd;
    jse_cmd_t rd_cmd;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_valid;

    assign in_stall = q_full;

    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (wr_cmd)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  (wr_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_data  (rd_cmd)
    );

    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (rd_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

[tb/tb_json_string_escaper.sv]
// ----------------------------------------------------------------------------
// tb_json_string_escaper
// Self-checking testbench for the JSON string escaper. A directed run covers
// the escapes, control bytes, bad lead bytes and broken or cut-off UTF-8
// sequences. Random strings follow: mostly printable text and valid UTF-8,
// with truncated sequences and stray high bytes mixed in. A scoreboard
// predicts every output character and compares it with the block's output,
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_json_string_escaper;
    import jse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_DEL = 8'h7F;
    localparam logic [7:0] CH_LOW_U = "u";
    localparam logic [7:0] CH_LOW_D = "d";
    localparam logic [7:0] CH_ZERO  = "0";

    localparam int ITEM_TARGET = 500;
    localparam int IDLE_LIMIT  = 2000;

    class literal_scoreboard;
        typedef struct {
            logic [7:0] ch;
            logic       last;
            logic       done;
        } lit_char_t;

        lit_char_t   pending_chars[$];
        bit          str_open;
        logic [7:0]  held[3];
        int unsigned held_n;
        int          errors;

        function void push_char(logic [7:0] c, logic d);
            lit_char_t e;
            e.ch   = c;
            e.last = 1'b0;
            e.done = d;
            pending_chars.insert(pending_chars.size(), e);
        endfunction

        function void push_fffd();
            push_char(CH_BSLASH, 1'b0);
            push_char(CH_LOW_U, 1'b0);
            push_char(CH_LOW_F, 1'b0);
            push_char(CH_LOW_F, 1'b0);
            push_char(CH_LOW_F, 1'b0);
            push_char(CH_LOW_D, 1'b0);
        endfunction

        function void flush_held();
            for (int i = 0; i < held_n; i++)
                push_fffd();
            held_n = 0;
        endfunction

        function void fresh_byte(logic [7:0] b);
            string      hexd;
            logic [7:0] letter;
            hexd   = "0123456789abcdef";
            letter = 8'h00;
            if (b >= 8'h80)
            begin
                if (b >= 8'hC2 && b <= 8'hF4)
                begin
                    held[0] = b;
                    held_n  = 1;
                end
                else
                    push_fffd();
                return;
            end
            case (b)
                CH_QUOTE:  letter = CH_QUOTE;
                CH_BSLASH: letter = CH_BSLASH;
                CTL_BS:    letter = CH_LOW_B;
                CTL_FF:    letter = CH_LOW_F;
                CTL_LF:    letter = CH_LOW_N;
                CTL_CR:    letter = CH_LOW_R;
                CTL_TAB:   letter = CH_LOW_T;
                default:   letter = 8'h00;
            endcase
            if (letter != 8'h00)
            begin
                push_char(CH_BSLASH, 1'b0);
                push_char(letter, 1'b0);
            end
            else if (b < 8'h20)
            begin
                push_char(CH_BSLASH, 1'b0);
                push_char(CH_LOW_U, 1'b0);
                push_char(CH_ZERO, 1'b0);
                push_char(CH_ZERO, 1'b0);
                push_char(hexd[b[7:4]], 1'b0);
                push_char(hexd[b[3:0]], 1'b0);
            end
            else
                push_char(b, 1'b0);
        endfunction

        function void next_byte(logic [7:0] b);
            logic [7:0]  lead;
            logic [7:0]  lo;
            logic [7:0]  hi;
            int unsigned need;
            if (held_n == 0)
            begin
                fresh_byte(b);
                return;
            end
            lead = held[0];
            lo   = 8'h80;
            hi   = 8'hBF;
            if (held_n == 1)
            begin
                case (lead)
                    8'hE0:   lo = 8'hA0;
                    8'hED:   hi = 8'h9F;
                    8'hF0:   lo = 8'h90;
                    8'hF4:   hi = 8'h8F;
                    default: ;
                endcase
            end
            need = (lead < 8'hE0) ? 2 : (lead < 8'hF0) ? 3 : 4;
            if (b < lo || b > hi)
            begin
                flush_held();
                fresh_byte(b);
            end
            else if (held_n + 1 >= need)
            begin
                for (int i = 0; i < held_n; i++)
                    push_char(held[i], 1'b0);
                push_char(b, 1'b0);
                held_n = 0;
            end
            else
            begin
                held[held_n] = b;
                held_n++;
            end
        endfunction

        function void note_request(logic [1:0] k, logic [7:0] b);
            int n0;
            n0 = pending_chars.size();
            if (!str_open)
            begin
                push_char(CH_QUOTE, 1'b0);
                str_open = 1'b1;
            end
            if (k <= KIND_LAST)
                next_byte(b);
            if (k >= KIND_LAST)
            begin
                flush_held();
                push_char(CH_QUOTE, 1'b1);
                str_open = 1'b0;
            end
            if (pending_chars.size() > n0)
                pending_chars[pending_chars.size() - 1].last = 1'b1;
        endfunction

        function void check_char(logic [7:0] c, logic l, logic d);
            lit_char_t e;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected out_char 0x%02h", c);
                errors++;
                return;
            end
            e = pending_chars.pop_front();
            if (c !== e.ch)
            begin
                $error("out_char: expected 0x%02h, got 0x%02h", e.ch, c);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("run_last: expected %0b, got %0b", e.last, l);
                errors++;
            end
            if (d !== e.done)
            begin
                $error("string_done: expected %0b, got %0b", e.done, d);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = KIND_BYTE;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       run_last;
    logic       string_done;

    literal_scoreboard sb = new();
    bit in_quiet;
    int items_sent;

    json_string_escaper uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .string_done (string_done)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic drive_request(logic [1:0] k, logic [7:0] b);
        int gap;
        gap = in_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(k, b);
        items_sent++;
    endtask

    task automatic send_string();
        logic [7:0]  str_bytes[$];
        logic [7:0]  enc[4];
        logic [20:0] cp;
        int          len;
        int          nb;
        int          keep;
        int          r;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        while (str_bytes.size() < len)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                str_bytes.insert(str_bytes.size(), 8'($urandom_range(8'h20, 8'h7E)));
            else if (r < 50)
            begin
                case ($urandom_range(0, 2))
                    0:       str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 31)));
                    1:
                    begin
                        str_bytes.insert(str_bytes.size(),
                                         $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
                    end
                    default: str_bytes.insert(str_bytes.size(), CTL_DEL);
                endcase
            end
            else if (r < 90)
            begin
                case ($urandom_range(2, 4))
                    2:
                    begin
                        cp     = 21'($urandom_range(21'h80, 21'h7FF));
                        enc[0] = 8'hC0 | cp[10:6];
                        enc[1] = 8'h80 | cp[5:0];
                        nb     = 2;
                    end
                    3:
                    begin
                        do
                            cp = 21'($urandom_range(21'h800, 21'hFFFF));
                        while (cp >= 21'hD800 && cp <= 21'hDFFF);
                        enc[0] = 8'hE0 | cp[15:12];
                        enc[1] = 8'h80 | cp[11:6];
                        enc[2] = 8'h80 | cp[5:0];
                        nb     = 3;
                    end
                    default:
                    begin
                        cp     = 21'($urandom_range(21'h10000, 21'h10FFFF));
                        enc[0] = 8'hF0 | cp[20:18];
                        enc[1] = 8'h80 | cp[17:12];
                        enc[2] = 8'h80 | cp[11:6];
                        enc[3] = 8'h80 | cp[5:0];
                        nb     = 4;
                    end
                endcase
                // cut the sequence short now and then
                keep = (r >= 80) ? $urandom_range(1, nb - 1) : nb;
                for (int i = 0; i < keep; i++)
                    str_bytes.insert(str_bytes.size(), enc[i]);
            end
            else
                str_bytes.insert(str_bytes.size(), 8'($urandom_range(8'h80, 8'hFF)));
        end
        if (str_bytes.size() == 0)
        begin
            drive_request($urandom_range(0, 1) ? KIND_END : KIND_UNUSED, 8'($urandom));
            return;
        end
        for (int i = 0; i < str_bytes.size() - 1; i++)
            drive_request(KIND_BYTE, str_bytes[i]);
        r = $urandom_range(0, 99);
        if (r < 60)
            drive_request(KIND_LAST, str_bytes[str_bytes.size() - 1]);
        else
        begin
            drive_request(KIND_BYTE, str_bytes[str_bytes.size() - 1]);
            drive_request(r < 90 ? KIND_END : KIND_UNUSED, 8'($urandom));
        end
    endtask

    // output backpressure
    initial
    begin
        int run;
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            out_stall <= 1'b1;
            repeat (1 + pick_gap()) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_char(out_char, run_last, string_done);
    end

    // watchdog: cycles with no request moving on either side
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] directed[$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty strings, unused kind
        drive_request(KIND_END, 8'h41);
        drive_request(KIND_UNUSED, 8'hAA);
        // escapes, control bytes, bad lead bytes
        directed = '{CH_QUOTE, CH_BSLASH, CTL_BS, CTL_FF, CTL_LF, CTL_CR, CTL_TAB,
                     8'h00, 8'h1F, 8'h20, CTL_DEL, 8'hFF, 8'h80, 8'hF5};
        foreach (directed[i])
            drive_request(KIND_BYTE, directed[i]);
        drive_request(KIND_LAST, 8'hC1);
        // valid 3-byte at the lower edge, surrogate, above U+10FFFF, valid U+10FFFF
        directed = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'hF4, 8'h90,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80};
        foreach (directed[i])
            drive_request(KIND_BYTE, directed[i]);
        // string ends with three bytes held
        drive_request(KIND_END, 8'h00);
        // final byte starts a sequence
        drive_request(KIND_LAST, 8'hC3);

        while (items_sent < ITEM_TARGET)
        begin
            in_quiet = ($urandom_range(0, 7) == 0);
            send_string();
        end
        in_valid <= 1'b0;

        while (sb.pending_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
